[design/mrss_pkg.sv]
// Shared types and constants for the matrix row-sum sort block.
// Used by mrss_elem_ram, mrss_sorter and matrix_row_sum_sort.
`default_nettype none

package mrss_pkg;

    localparam int MAX_DIM   = 16;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int SIZE_W    = 5;
    localparam int ELEM_W    = 32;
    localparam int SUM_W     = 40;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic                    start;
        logic [DIM_W-1:0]        row;
        logic signed [SUM_W-1:0] key;
    } sort_cmd_t;

    function automatic logic [ADDR_W-1:0] elem_addr(
        input logic [DIM_W-1:0] row,
        input logic [DIM_W-1:0] col
    );
        elem_addr = ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

[design/matrix_row_sum_sort.sv]
// Row-sum sort of a square matrix. Load beats (mode 0) write elements row-major and
// keep a 40-bit running row sum; the beat that ends a row starts a stable insertion
// walk in the sorter, one compare-and-shift step per stored row it passes plus a final
// write, and input stalls until that walk is done; other load beats do not stall. Once the
// matrix is loaded, drain beats (mode 1) return the rows in ascending sum order, each
// through the registered element RAM read and the put state, with last on the final one.
// Beats of the wrong mode are taken and ignored. A size write (0 acts as 1, above 16
// as 16) restarts loading. Depends on mrss_pkg, mrss_elem_ram and mrss_sorter.
`default_nettype none

module matrix_row_sum_sort (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          matrix_size_we,
    input  wire logic [mrss_pkg::SIZE_W-1:0]   matrix_size_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          mode,
    input  wire logic signed [mrss_pkg::ELEM_W-1:0] value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [mrss_pkg::ELEM_W-1:0] element,
    output logic                               last
);

    mrss_pkg::state_t                   state_reg;
    mrss_pkg::state_t                   state_next;
    logic        [mrss_pkg::DIM_W-1:0]  nm1_reg;
    logic        [mrss_pkg::DIM_W-1:0]  nm1_next;
    logic signed [mrss_pkg::SUM_W-1:0]  acc_reg;
    logic signed [mrss_pkg::SUM_W-1:0]  sum_next;
    logic        [mrss_pkg::DIM_W-1:0]  load_row_reg;
    logic        [mrss_pkg::DIM_W-1:0]  load_col_reg;
    logic        [mrss_pkg::DIM_W-1:0]  drain_row_reg;
    logic        [mrss_pkg::DIM_W-1:0]  drain_col_reg;
    logic                               loaded_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [mrss_pkg::ELEM_W-1:0] element_reg;
    logic                               last_reg;
    logic                               last_pend_reg;

    logic                               in_acc;
    logic                               ld_acc;
    logic                               dr_acc;
    logic                               row_end;
    logic                               fin;
    logic                               out_free;
    logic                               out_load;
    mrss_pkg::sort_cmd_t                sort_cmd;
    logic                               sort_done;
    logic        [mrss_pkg::DIM_W-1:0]  order_rd;
    logic        [mrss_pkg::ELEM_W-1:0] ram_rdata;

    assign in_stall  = (state_reg != mrss_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign row_end   = (load_col_reg == nm1_reg);
    assign fin       = (drain_row_reg == nm1_reg) && (drain_col_reg == nm1_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign sum_next  = acc_reg + mrss_pkg::SUM_W'(value);

    always_comb
    begin
        if (matrix_size_wdata == '0)
        begin
            nm1_next = '0;
        end
        else if (matrix_size_wdata > mrss_pkg::SIZE_W'(mrss_pkg::MAX_DIM))
        begin
            nm1_next = mrss_pkg::DIM_W'(mrss_pkg::MAX_DIM - 1);
        end
        else
        begin
            nm1_next = mrss_pkg::DIM_W'(matrix_size_wdata - mrss_pkg::SIZE_W'(1));
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrss_pkg::ST_IDLE:
            begin
                if (ld_acc && row_end)
                begin
                    state_next = mrss_pkg::ST_INSERT;
                end
                else if (dr_acc)
                begin
                    state_next = mrss_pkg::ST_PUT;
                end
            end
            mrss_pkg::ST_INSERT:
            begin
                if (sort_done)
                begin
                    state_next = mrss_pkg::ST_IDLE;
                end
            end
            mrss_pkg::ST_PUT:
            begin
                if (out_free)
                begin
                    state_next = mrss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrss_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ld_acc         = in_acc && !mode && !loaded_reg;
        dr_acc         = in_acc && mode && loaded_reg;
        out_load       = (state_reg == mrss_pkg::ST_PUT) && out_free;
        sort_cmd.start = ld_acc && row_end;
        sort_cmd.row   = load_row_reg;
        sort_cmd.key   = sum_next;
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrss_pkg::ST_IDLE;
            nm1_reg       <= mrss_pkg::DIM_W'(mrss_pkg::MAX_DIM - 1);
            acc_reg       <= '0;
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            drain_row_reg <= '0;
            drain_col_reg <= '0;
            loaded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (matrix_size_we)
            begin
                nm1_reg       <= nm1_next;
                acc_reg       <= '0;
                load_row_reg  <= '0;
                load_col_reg  <= '0;
                drain_row_reg <= '0;
                drain_col_reg <= '0;
                loaded_reg    <= 1'b0;
            end
            else if (ld_acc)
            begin
                if (row_end)
                begin
                    acc_reg      <= '0;
                    load_col_reg <= '0;
                    if (load_row_reg == nm1_reg)
                    begin
                        load_row_reg  <= '0;
                        drain_row_reg <= '0;
                        drain_col_reg <= '0;
                        loaded_reg    <= 1'b1;
                    end
                    else
                    begin
                        load_row_reg <= load_row_reg + mrss_pkg::DIM_W'(1);
                    end
                end
                else
                begin
                    acc_reg      <= sum_next;
                    load_col_reg <= load_col_reg + mrss_pkg::DIM_W'(1);
                end
            end
            else if (dr_acc)
            begin
                if (fin)
                begin
                    acc_reg       <= '0;
                    load_row_reg  <= '0;
                    load_col_reg  <= '0;
                    drain_row_reg <= '0;
                    drain_col_reg <= '0;
                    loaded_reg    <= 1'b0;
                end
                else if (drain_col_reg == nm1_reg)
                begin
                    drain_col_reg <= '0;
                    drain_row_reg <= drain_row_reg + mrss_pkg::DIM_W'(1);
                end
                else
                begin
                    drain_col_reg <= drain_col_reg + mrss_pkg::DIM_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dr_acc)
        begin
            last_pend_reg <= fin;
        end
        if (out_load)
        begin
            element_reg <= ram_rdata;
            last_reg    <= last_pend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign element   = element_reg;
    assign last      = last_reg;

    mrss_elem_ram u_ram (
        .clk   (clk),
        .we    (ld_acc),
        .waddr (mrss_pkg::elem_addr(load_row_reg, load_col_reg)),
        .wdata (value),
        .re    (dr_acc),
        .raddr (mrss_pkg::elem_addr(order_rd, drain_col_reg)),
        .rdata (ram_rdata)
    );

    mrss_sorter u_sorter (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (sort_cmd),
        .rd_idx   (drain_row_reg),
        .order_rd (order_rd),
        .done     (sort_done)
    );

`ifndef SYNTHESIS
    a_done_in_insert: assert property (@(posedge clk) disable iff (!rst_n)
        sort_done |-> state_reg == mrss_pkg::ST_INSERT)
        else $error("sorter finished outside insert state");

    a_loaded_after_row: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(loaded_reg) |-> $past(sort_cmd.start) || $past(matrix_size_we))
        else $error("drain phase entered without a row insert");

    a_out_from_put: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == mrss_pkg::ST_PUT))
        else $error("output beat raised outside put state");

    a_acc_clear_drain: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg |-> acc_reg == '0 && load_col_reg == '0)
        else $error("load state not clear while draining");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_col_reg <= nm1_reg && drain_col_reg <= nm1_reg)
        else $error("column position past matrix size");
`endif

endmodule

`default_nettype wire

[design/mrss_elem_ram.sv]
// Element store: one write port, one read port with registered read data.
// Depends on mrss_pkg for depth and widths.
`default_nettype none

module mrss_elem_ram (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [mrss_pkg::ADDR_W-1:0] waddr,
    input  wire logic [mrss_pkg::ELEM_W-1:0] wdata,
    input  wire logic                       re,
    input  wire logic [mrss_pkg::ADDR_W-1:0] raddr,
    output logic      [mrss_pkg::ELEM_W-1:0] rdata
);

    logic [mrss_pkg::ELEM_W-1:0] mem_reg [mrss_pkg::MEM_DEPTH];
    logic [mrss_pkg::ELEM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/mrss_sorter.sv]
// Stable insertion of row sums, one compare-and-shift step per cycle.
// Holds sorted sums and row order; depends on mrss_pkg.
`default_nettype none

module mrss_sorter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mrss_pkg::sort_cmd_t           cmd,
    input  wire logic [mrss_pkg::DIM_W-1:0]    rd_idx,
    output logic      [mrss_pkg::DIM_W-1:0]    order_rd,
    output logic                               done
);

    logic signed [mrss_pkg::SUM_W-1:0] keys_reg  [mrss_pkg::MAX_DIM];
    logic        [mrss_pkg::DIM_W-1:0] order_reg [mrss_pkg::MAX_DIM];
    logic        [mrss_pkg::DIM_W-1:0] pos_reg;
    logic        [mrss_pkg::DIM_W-1:0] row_reg;
    logic signed [mrss_pkg::SUM_W-1:0] key_reg;
    logic                              busy_reg;
    logic                              busy_next;
    logic        [mrss_pkg::DIM_W-1:0] prev;
    logic        [mrss_pkg::DIM_W-1:0] rd_addr;
    logic                              shift;

    assign prev     = pos_reg - mrss_pkg::DIM_W'(1);
    assign rd_addr  = busy_reg ? prev : rd_idx;
    assign order_rd = order_reg[rd_addr];
    assign shift    = busy_reg && (pos_reg != '0) && (keys_reg[prev] > key_reg);
    assign done     = busy_reg && !shift;

    always_comb
    begin
        busy_next = busy_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pos_reg <= cmd.row;
            row_reg <= cmd.row;
            key_reg <= cmd.key;
        end
        else if (shift)
        begin
            keys_reg[pos_reg]  <= keys_reg[prev];
            order_reg[pos_reg] <= order_rd;
            pos_reg            <= prev;
        end
        else if (busy_reg)
        begin
            keys_reg[pos_reg]  <= key_reg;
            order_reg[pos_reg] <= row_reg;
        end
    end

endmodule

`default_nettype wire
